// ===== hdl/htbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htbd_pkg
// Shared types and status codes for the hex text to byte decoder.
// ----------------------------------------------------------------------------
package htbd_pkg;

  // status codes carried on the result channel
  localparam logic [1:0] STAT_RUNNING = 2'd0;
  localparam logic [1:0] STAT_OK      = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;
  localparam logic [1:0] STAT_EMPTY   = 2'd3;

  typedef struct packed {
    logic [7:0] text_char;
    logic       final_char;
  } htbd_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_end;
    logic [1:0] status;
  } htbd_out_t;

endpackage

// ===== hdl/hex_text_to_byte_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_text_to_byte_decoder
// Turns a stream of hex text characters into bytes, with end-of-text status.
// ----------------------------------------------------------------------------
// Flow: a character is registered into the input stage on acceptance; its results
//   are registered into the result buffer, which drives out_*, once it is free.
// Throughput: one character per cycle while out_ready is high; a character that
//   finishes two bytes (only possible on the final character) holds the input
//   stage while the second result drains from the two-entry result buffer.
// Reset: rst_n synchronous, active low; clears both stages and decode state.
module hex_text_to_byte_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  htbd_pkg::htbd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output htbd_pkg::htbd_out_t out_data
);
  import htbd_pkg::*;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_X    = 8'h78;

  // input stage
  logic     s1_valid_r;
  htbd_in_t s1_data_r;
  logic     s1_adv;

  // decode state
  logic [7:0] partial_byte_r, partial_byte_nxt;
  logic       nibble_open_r,  nibble_open_nxt;
  logic       zero_held_r,    zero_held_nxt;
  logic       bad_seen_r,     bad_seen_nxt;
  logic       any_emitted_r,  any_emitted_nxt;

  // result buffer: two slots, head in q0
  htbd_out_t  q0_r, q1_r;
  logic [1:0] cnt_r;
  logic       pop;
  logic       buf_free;

  // step results
  htbd_out_t  r0, r1;
  logic [1:0] r_cnt;

  // decode scratch
  logic [7:0] c;
  logic       fin;
  logic       is_dig, is_hex, is_sep;
  logic [3:0] hex_val;
  logic       p_a, p_b, p_c;
  logic [7:0] v_a, v_b, v_c;
  logic       consumed;
  logic [1:0] st;

  assign pop      = out_valid && out_ready;
  // buffer is empty once this cycle's pop is done
  assign buf_free = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);
  assign s1_adv   = s1_valid_r && buf_free;
  assign in_ready = !s1_valid_r || buf_free;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q0_r;

  // character classes
  always_comb begin
    c       = s1_data_r.text_char;
    fin     = s1_data_r.final_char;
    is_dig  = c inside {[8'h30:8'h39]};
    is_hex  = is_dig || (c inside {[8'h41:8'h46], [8'h61:8'h66]});
    // whitespace or printable punctuation
    is_sep  = c inside {[8'h09:8'h0D], 8'h20, [8'h21:8'h2F], [8'h3A:8'h40],
                        [8'h5B:8'h60], [8'h7B:8'h7E]};
    hex_val = is_dig ? c[3:0] : (c[3:0] + 4'd9);
  end

  // one decode step; up to three byte pushes in order, at most two occur
  always_comb begin
    partial_byte_nxt = partial_byte_r;
    nibble_open_nxt  = nibble_open_r;
    zero_held_nxt    = zero_held_r;
    bad_seen_nxt     = bad_seen_r;
    any_emitted_nxt  = any_emitted_r;
    p_a = 1'b0; p_b = 1'b0; p_c = 1'b0;
    v_a = 8'h00; v_b = 8'h00; v_c = 8'h00;
    consumed = 1'b0;

    if (!bad_seen_r) begin
      // held '0' resolves against this character
      if (zero_held_r) begin
        zero_held_nxt = 1'b0;
        if (c == CH_X) begin
          p_a             = nibble_open_nxt;
          v_a             = partial_byte_nxt;
          nibble_open_nxt = 1'b0;
          consumed        = 1'b1;
        end else if (nibble_open_nxt) begin
          p_a             = 1'b1;
          v_a             = {partial_byte_nxt[3:0], 4'h0};
          nibble_open_nxt = 1'b0;
        end else begin
          partial_byte_nxt = 8'h00;
          nibble_open_nxt  = 1'b1;
        end
      end

      if (!consumed) begin
        if (is_hex) begin
          if ((c == CH_ZERO) && !fin) begin
            zero_held_nxt = 1'b1;
          end else if (nibble_open_nxt) begin
            p_b             = 1'b1;
            v_b             = {partial_byte_nxt[3:0], hex_val};
            nibble_open_nxt = 1'b0;
          end else begin
            partial_byte_nxt = {4'h0, hex_val};
            nibble_open_nxt  = 1'b1;
          end
        end else if (is_sep) begin
          p_b             = nibble_open_nxt;
          v_b             = partial_byte_nxt;
          nibble_open_nxt = 1'b0;
        end else begin
          bad_seen_nxt    = 1'b1;
          nibble_open_nxt = 1'b0;
          zero_held_nxt   = 1'b0;
        end
      end

      // end of text flushes an open nibble
      if (fin && !bad_seen_nxt) begin
        p_c             = nibble_open_nxt;
        v_c             = partial_byte_nxt;
        nibble_open_nxt = 1'b0;
      end
    end

    any_emitted_nxt = any_emitted_nxt || p_a || p_b || p_c;

    if (bad_seen_nxt) begin
      st = STAT_INVALID;
    end else if (any_emitted_nxt) begin
      st = STAT_OK;
    end else begin
      st = STAT_EMPTY;
    end

    r_cnt = {1'b0, p_a} + {1'b0, p_b} + {1'b0, p_c};

    // pack pushes into result slots; a status-only result carries a zero byte
    r0.data_byte  = p_a ? v_a : (p_b ? v_b : (p_c ? v_c : 8'h00));
    r0.byte_valid = (r_cnt != 2'd0);
    r0.run_end    = fin && (r_cnt != 2'd2);
    r0.status     = r0.run_end ? st : STAT_RUNNING;
    r1.data_byte  = (p_a && p_b) ? v_b : v_c;
    r1.byte_valid = 1'b1;
    r1.run_end    = fin;
    r1.status     = fin ? st : STAT_RUNNING;

    // final character always yields at least one result
    if (fin && (r_cnt == 2'd0)) begin
      r_cnt = 2'd1;
    end

    // text ends: back to reset state
    if (fin) begin
      partial_byte_nxt = 8'h00;
      nibble_open_nxt  = 1'b0;
      zero_held_nxt    = 1'b0;
      bad_seen_nxt     = 1'b0;
      any_emitted_nxt  = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      cnt_r          <= 2'd0;
      partial_byte_r <= 8'h00;
      nibble_open_r  <= 1'b0;
      zero_held_r    <= 1'b0;
      bad_seen_r     <= 1'b0;
      any_emitted_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        partial_byte_r <= partial_byte_nxt;
        nibble_open_r  <= nibble_open_nxt;
        zero_held_r    <= zero_held_nxt;
        bad_seen_r     <= bad_seen_nxt;
        any_emitted_r  <= any_emitted_nxt;
        cnt_r          <= r_cnt;
      end else if (pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      q0_r <= r0;
      q1_r <= r1;
    end else if (pop) begin
      q0_r <= q1_r;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_bad_clears: assert property (@(posedge clk) disable iff (!rst_n)
    bad_seen_r |-> (!nibble_open_r && !zero_held_r))
    else $error("nibble or held zero live after invalid character");

  a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_data_r.final_char) |=>
      (!bad_seen_r && !nibble_open_r && !zero_held_r && !any_emitted_r))
    else $error("decode state not cleared after end of text");

  a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_data_r.final_char) |=> (cnt_r != 2'd0))
    else $error("end of text gave no result");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && !buf_free))
    else $error("input stalled while buffer free");
`endif

endmodule
